[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the irrigation pump controller.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/ipc_pkg.sv]
// Types and constants of the irrigation pump controller.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ipc_pkg;

  localparam int FIELD_TIME_W = 32;
  localparam int PCT_W        = 7;
  localparam int STATUS_W     = 4;
  localparam int FAULT_W      = 8;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 5;
  localparam int REG_IDX_W    = 3;

  typedef logic [PCT_W-1:0]        pct_t;
  typedef logic [STATUS_W-1:0]     status_t;
  typedef logic [FAULT_W-1:0]      fault_t;
  typedef logic [FIELD_TIME_W-1:0] ms_t;
  typedef logic [REG_IDX_W-1:0]    reg_idx_t;

  localparam status_t ST_OK          = 4'd0;
  localparam status_t ST_START       = 4'd1;
  localparam status_t ST_RUNNING     = 4'd2;
  localparam status_t ST_TARGET      = 4'd3;
  localparam status_t ST_COOLDOWN    = 4'd4;
  localparam status_t ST_TOO_SOON    = 4'd5;
  localparam status_t ST_CUTOFF      = 4'd6;
  localparam status_t ST_NO_WATER    = 4'd7;
  localparam status_t ST_MOIST_FAULT = 4'd8;
  localparam status_t ST_CRITICAL    = 4'd9;
  localparam status_t ST_TANK_FAULT  = 4'd10;

  localparam reg_idx_t REG_MOISTURE_LOW  = 3'd0;
  localparam reg_idx_t REG_MOISTURE_HIGH = 3'd1;
  localparam reg_idx_t REG_TANK_LOW      = 3'd2;
  localparam reg_idx_t REG_TANK_SAFE     = 3'd3;
  localparam reg_idx_t REG_COOLDOWN      = 3'd4;
  localparam reg_idx_t REG_MIN_INTERVAL  = 3'd5;
  localparam reg_idx_t REG_MAX_RUN       = 3'd6;
  localparam reg_idx_t REG_MAX_FAULTS    = 3'd7;

  localparam pct_t   RST_MOISTURE_LOW  = 7'd30;
  localparam pct_t   RST_MOISTURE_HIGH = 7'd60;
  localparam pct_t   RST_TANK_LOW      = 7'd10;
  localparam pct_t   RST_TANK_SAFE     = 7'd20;
  localparam ms_t    RST_COOLDOWN      = 32'd60000;
  localparam ms_t    RST_MIN_INTERVAL  = 32'd300000;
  localparam ms_t    RST_MAX_RUN       = 32'd30000;
  localparam fault_t RST_MAX_FAULTS    = 8'd5;
  localparam fault_t FAULT_SAT         = 8'd255;

endpackage

`default_nettype wire

[hw/rtl/ipc_stream_if.sv]
// Valid/ready channels of the irrigation pump controller: samples in, results out.
// Depends on ipc_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface ipc_smp_if;
  logic          valid;
  logic          ready;
  ipc_pkg::ms_t  now_ms;
  ipc_pkg::pct_t moisture_pct;
  logic          moisture_ok;
  ipc_pkg::pct_t tank_pct;
  logic          tank_ok;

  modport source (output valid, now_ms, moisture_pct, moisture_ok, tank_pct, tank_ok,
                  input ready);
  modport sink (input valid, now_ms, moisture_pct, moisture_ok, tank_pct, tank_ok,
                output ready);
endinterface

interface ipc_res_if;
  logic             valid;
  logic             ready;
  logic             pump_on;
  ipc_pkg::status_t status;
  ipc_pkg::fault_t  fault_count;
  ipc_pkg::ms_t     on_time_ms;

  modport source (output valid, pump_on, status, fault_count, on_time_ms, input ready);
  modport sink (input valid, pump_on, status, fault_count, on_time_ms, output ready);
endinterface

`default_nettype wire

[hw/rtl/irrigation_pump_hysteresis_controller_top.sv]
// Irrigation pump hysteresis controller: sample register, decision logic, result register.
// Depends on ipc_pkg, ipc_stream_if.sv and assert_macros.svh.
//
// Usage: control samples enter on the smp channel and one result per sample
// leaves on the res channel, both valid/ready. An item is taken when valid and
// ready are high at a rising clock edge. Thresholds and timers must be written
// through the APB port only while the block is idle; the block itself does not
// enforce this. Reads return the register value. A sample in the sample register
// feeds the decision logic, which loads the result register when that register
// is free; res.valid rises with the loaded result.
// Throughput is one item per cycle while res.ready stays high, set by the update
// of the pump state registers that each sample reads and writes.
// When the receiver stalls, the result register holds its item and the sample
// register holds the next one; smp.ready then drops until res.ready returns.
// Synchronous reset clears both stages, turns the pump off, sets the start and
// end times to never, clears the fault count and loads the default thresholds.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module irrigation_pump_hysteresis_controller_top #(
  parameter int TIME_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  ipc_smp_if.sink                           smp,
  ipc_res_if.source                         res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ipc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ipc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ipc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int CW = (TIME_BITS > ipc_pkg::FIELD_TIME_W) ? TIME_BITS : ipc_pkg::FIELD_TIME_W;

  // Configuration registers.
  ipc_pkg::pct_t   moisture_low;
  ipc_pkg::pct_t   moisture_high;
  ipc_pkg::pct_t   tank_low;
  ipc_pkg::pct_t   tank_safe;
  ipc_pkg::ms_t    cooldown_ms;
  ipc_pkg::ms_t    min_interval_ms;
  ipc_pkg::ms_t    max_run_ms;
  ipc_pkg::fault_t max_faults;

  ipc_pkg::reg_idx_t reg_idx;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[ipc_pkg::APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      moisture_low    <= ipc_pkg::RST_MOISTURE_LOW;
      moisture_high   <= ipc_pkg::RST_MOISTURE_HIGH;
      tank_low        <= ipc_pkg::RST_TANK_LOW;
      tank_safe       <= ipc_pkg::RST_TANK_SAFE;
      cooldown_ms     <= ipc_pkg::RST_COOLDOWN;
      min_interval_ms <= ipc_pkg::RST_MIN_INTERVAL;
      max_run_ms      <= ipc_pkg::RST_MAX_RUN;
      max_faults      <= ipc_pkg::RST_MAX_FAULTS;
    end else if (cfg_write) begin
      unique case (reg_idx)
        ipc_pkg::REG_MOISTURE_LOW:  moisture_low    <= pwdata[ipc_pkg::PCT_W-1:0];
        ipc_pkg::REG_MOISTURE_HIGH: moisture_high   <= pwdata[ipc_pkg::PCT_W-1:0];
        ipc_pkg::REG_TANK_LOW:      tank_low        <= pwdata[ipc_pkg::PCT_W-1:0];
        ipc_pkg::REG_TANK_SAFE:     tank_safe       <= pwdata[ipc_pkg::PCT_W-1:0];
        ipc_pkg::REG_COOLDOWN:      cooldown_ms     <= pwdata;
        ipc_pkg::REG_MIN_INTERVAL:  min_interval_ms <= pwdata;
        ipc_pkg::REG_MAX_RUN:       max_run_ms      <= pwdata;
        ipc_pkg::REG_MAX_FAULTS:    max_faults      <= pwdata[ipc_pkg::FAULT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ipc_pkg::REG_MOISTURE_LOW:  prdata = ipc_pkg::APB_DATA_W'(moisture_low);
      ipc_pkg::REG_MOISTURE_HIGH: prdata = ipc_pkg::APB_DATA_W'(moisture_high);
      ipc_pkg::REG_TANK_LOW:      prdata = ipc_pkg::APB_DATA_W'(tank_low);
      ipc_pkg::REG_TANK_SAFE:     prdata = ipc_pkg::APB_DATA_W'(tank_safe);
      ipc_pkg::REG_COOLDOWN:      prdata = cooldown_ms;
      ipc_pkg::REG_MIN_INTERVAL:  prdata = min_interval_ms;
      ipc_pkg::REG_MAX_RUN:       prdata = max_run_ms;
      ipc_pkg::REG_MAX_FAULTS:    prdata = ipc_pkg::APB_DATA_W'(max_faults);
    endcase
  end

  // Sample register.
  logic          s1_valid;
  ipc_pkg::ms_t  s1_now_ms;
  ipc_pkg::pct_t s1_moisture_pct;
  logic          s1_moisture_ok;
  ipc_pkg::pct_t s1_tank_pct;
  logic          s1_tank_ok;

  // Result register.
  logic             out_valid;
  logic             out_pump_on;
  ipc_pkg::status_t out_status;
  ipc_pkg::fault_t  out_fault_count;
  ipc_pkg::ms_t     out_on_time_ms;

  logic out_free;
  logic s1_fire;
  logic smp_take;

  assign out_free = !out_valid || res.ready;
  assign s1_fire  = s1_valid && out_free;
  assign smp.ready = !s1_valid || out_free;
  assign smp_take = smp.valid && smp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (smp_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_take) begin
      s1_now_ms       <= smp.now_ms;
      s1_moisture_pct <= smp.moisture_pct;
      s1_moisture_ok  <= smp.moisture_ok;
      s1_tank_pct     <= smp.tank_pct;
      s1_tank_ok      <= smp.tank_ok;
    end
  end

  // Pump state.
  logic                 pump_was_on;
  logic [TIME_BITS-1:0] run_start_ms;
  logic [TIME_BITS-1:0] last_start_ms;
  logic [TIME_BITS-1:0] last_end_ms;
  ipc_pkg::fault_t      fault_counter;

  logic                 pump_was_on_next;
  logic [TIME_BITS-1:0] run_start_ms_next;
  logic [TIME_BITS-1:0] last_start_ms_next;
  logic [TIME_BITS-1:0] last_end_ms_next;
  ipc_pkg::fault_t      fault_counter_next;

  logic [CW-1:0]        now_ext;
  logic [TIME_BITS-1:0] tnow;
  logic [TIME_BITS-1:0] el_end;
  logic [TIME_BITS-1:0] el_start;
  logic [TIME_BITS-1:0] el_run;
  logic [TIME_BITS-1:0] el_on;
  logic [CW-1:0]        on_ext;
  ipc_pkg::fault_t      fault_inc;
  logic                 cool_hit;
  logic                 soon_hit;
  logic                 cut_hit;
  logic                 has_water;
  logic                 can_water;
  logic                 pump;
  ipc_pkg::status_t     status;

  assign now_ext   = CW'(s1_now_ms);
  assign tnow      = now_ext[TIME_BITS-1:0];
  assign el_end    = tnow - last_end_ms;
  assign el_start  = tnow - last_start_ms;
  assign el_run    = tnow - run_start_ms;
  assign fault_inc = (fault_counter == ipc_pkg::FAULT_SAT) ? fault_counter
                                                           : fault_counter + 8'd1;
  assign cool_hit  = (last_end_ms != '0) && (CW'(el_end) < CW'(cooldown_ms));
  assign soon_hit  = (last_start_ms != '0) && (CW'(el_start) < CW'(min_interval_ms));
  assign cut_hit   = pump_was_on && (CW'(el_run) > CW'(max_run_ms));
  assign has_water = pump_was_on ? (s1_tank_pct > tank_low) : (s1_tank_pct > tank_safe);
  assign can_water = !cool_hit && !soon_hit && !cut_hit;

  always_comb begin
    pump_was_on_next   = pump_was_on;
    run_start_ms_next  = run_start_ms;
    last_start_ms_next = last_start_ms;
    last_end_ms_next   = last_end_ms;
    fault_counter_next = fault_counter;
    pump               = 1'b0;
    status             = ipc_pkg::ST_OK;
    if (!s1_moisture_ok) begin
      fault_counter_next = fault_inc;
      if (fault_inc >= max_faults) begin
        pump_was_on_next = 1'b0;
        status           = ipc_pkg::ST_CRITICAL;
      end else begin
        pump   = pump_was_on;
        status = ipc_pkg::ST_MOIST_FAULT;
      end
    end else begin
      fault_counter_next = '0;
      if (!s1_tank_ok) begin
        status = ipc_pkg::ST_TANK_FAULT;
      end else begin
        pump = pump_was_on;
        if (cool_hit) begin
          status = ipc_pkg::ST_COOLDOWN;
        end
        if (soon_hit) begin
          status = ipc_pkg::ST_TOO_SOON;
        end
        if (cut_hit) begin
          pump             = 1'b0;
          status           = ipc_pkg::ST_CUTOFF;
          last_end_ms_next = tnow;
        end
        if (can_water && has_water) begin
          if (pump_was_on) begin
            if (s1_moisture_pct >= moisture_high) begin
              pump             = 1'b0;
              last_end_ms_next = tnow;
              status           = ipc_pkg::ST_TARGET;
            end else begin
              status = ipc_pkg::ST_RUNNING;
            end
          end else if (s1_moisture_pct < moisture_low) begin
            pump               = 1'b1;
            run_start_ms_next  = tnow;
            last_start_ms_next = tnow;
            status             = ipc_pkg::ST_START;
          end else begin
            status = ipc_pkg::ST_OK;
          end
        end else if (!has_water) begin
          pump   = 1'b0;
          status = ipc_pkg::ST_NO_WATER;
        end
        pump_was_on_next = pump;
      end
    end
  end

  assign el_on  = tnow - run_start_ms_next;
  assign on_ext = CW'(el_on);

  always_ff @(posedge clk) begin
    if (rst) begin
      pump_was_on   <= 1'b0;
      run_start_ms  <= '0;
      last_start_ms <= '0;
      last_end_ms   <= '0;
      fault_counter <= '0;
    end else if (s1_fire) begin
      pump_was_on   <= pump_was_on_next;
      run_start_ms  <= run_start_ms_next;
      last_start_ms <= last_start_ms_next;
      last_end_ms   <= last_end_ms_next;
      fault_counter <= fault_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pump_on     <= pump;
      out_status      <= status;
      out_fault_count <= fault_counter_next;
      out_on_time_ms  <= pump ? on_ext[ipc_pkg::FIELD_TIME_W-1:0] : '0;
    end
  end

  assign res.valid       = out_valid;
  assign res.pump_on     = out_pump_on;
  assign res.status      = out_status;
  assign res.fault_count = out_fault_count;
  assign res.on_time_ms  = out_on_time_ms;

  `ASSERT_IMPLIES(a_pump_status, clk, rst, res.valid && res.pump_on,
                  res.status == ipc_pkg::ST_START || res.status == ipc_pkg::ST_RUNNING ||
                  res.status == ipc_pkg::ST_COOLDOWN || res.status == ipc_pkg::ST_TOO_SOON ||
                  res.status == ipc_pkg::ST_MOIST_FAULT)
  `ASSERT_IMPLIES(a_off_no_time, clk, rst, res.valid && !res.pump_on,
                  res.on_time_ms == '0)
  `ASSERT_IMPLIES(a_fault_count, clk, rst,
                  res.valid && (res.status == ipc_pkg::ST_MOIST_FAULT ||
                  res.status == ipc_pkg::ST_CRITICAL), res.fault_count != '0)
  `ASSERT_IMPLIES(a_start_times, clk, rst, $rose(pump_was_on),
                  run_start_ms == last_start_ms)
  `ASSERT_NEXT(a_state_on_fire, clk, rst, !s1_fire,
               $stable(pump_was_on) && $stable(fault_counter))

endmodule

`default_nettype wire
